// File: design/urmd_pkg.sv
package urmd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } rx_phase_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data;
    logic       framing_error;
  } rx_rec_t;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_BIT_PERIOD = 3'd0;

  localparam logic [15:0] BIT_PERIOD_RESET = 16'd1520;
  localparam logic [7:0]  NEWLINE = 8'h0A;
  localparam logic [2:0]  LAST_BIT = 3'd7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam int MARKER_TEXT_LEN = 28;
  localparam logic [4:0] MARKER_LEN = 5'd28;
  localparam logic [8*MARKER_TEXT_LEN-1:0] MARKER_STR = "Correct operation validated.";

  function automatic logic [7:0] marker_char(input logic [4:0] idx);
    int sh;
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < MARKER_TEXT_LEN) begin
      sh = 8 * (MARKER_TEXT_LEN - 1 - int'(idx));
      c = MARKER_STR[sh +: 8];
    end
    return c;
  endfunction

endpackage

// File: design/uart_rx_marker_detect.sv
// Each sample's record is written into the queue and then popped into the output
// registers, where out_valid rises; output stalls can hold records in the queue.
// Throughput: one sample per cycle while the queue is not full, one result per
// sample; a four-entry queue between the UART front end and the marker matcher absorbs output stalls.
// Reset is synchronous and active high: it clears the receiver, the queue and
// the matcher, and sets bit_period to 1520.
module uart_rx_marker_detect (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         line_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         byte_valid,
  output logic [7:0]                   data_byte,
  output logic                         framing_error,
  output logic                         completion,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [urmd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [15:0] bit_period;
  logic take, fifo_full, fifo_empty, pop;
  urmd_pkg::rx_rec_t front_rec, fifo_rec;

  assign pready = 1'b1;
  assign prdata = (paddr == urmd_pkg::REG_BIT_PERIOD) ? {16'd0, bit_period} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= urmd_pkg::BIT_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == urmd_pkg::REG_BIT_PERIOD) begin
      bit_period <= pwdata[15:0];
    end
  end

  assign in_ready = !fifo_full;
  assign take = in_valid && in_ready;

  urmd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bit_period (bit_period),
    .take       (take),
    .line_level (line_level),
    .rec        (front_rec)
  );

  urmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_rec (front_rec),
    .pop      (pop),
    .pop_rec  (fifo_rec),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  urmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_empty    (fifo_empty),
    .rec           (fifo_rec),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_valid    (byte_valid),
    .data_byte     (data_byte),
    .framing_error (framing_error),
    .completion    (completion)
  );

endmodule

// File: design/urmd_front.sv
module urmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       bit_period,
  input  logic              take,
  input  logic              line_level,
  output urmd_pkg::rx_rec_t rec
);

  urmd_pkg::rx_phase_t phase, phase_next;
  logic [15:0] bit_timer, bit_timer_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [14:0] half;
  logic [15:0] half_reload, full_reload;

  assign half = bit_period[15:1];
  assign half_reload = (half == 15'd0) ? 16'd0 : {1'b0, half} - 16'd1;
  assign full_reload = (bit_period == 16'd0) ? 16'd0 : bit_period - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= urmd_pkg::PH_IDLE;
      bit_timer <= 16'd0;
      bit_index <= 3'd0;
      shift_byte <= 8'd0;
    end else if (take) begin
      phase <= phase_next;
      bit_timer <= bit_timer_next;
      bit_index <= bit_index_next;
      shift_byte <= shift_byte_next;
    end
  end

  always_comb begin
    phase_next = phase;
    bit_timer_next = bit_timer;
    bit_index_next = bit_index;
    shift_byte_next = shift_byte;
    rec = '0;
    case (phase)
      urmd_pkg::PH_IDLE: begin
        if (!line_level) begin
          phase_next = urmd_pkg::PH_START;
          bit_timer_next = half_reload;
        end
      end
      urmd_pkg::PH_START: begin
        if (bit_timer == 16'd0) begin
          if (!line_level) begin
            phase_next = urmd_pkg::PH_DATA;
            bit_timer_next = full_reload;
            bit_index_next = 3'd0;
            shift_byte_next = 8'd0;
          end else begin
            phase_next = urmd_pkg::PH_IDLE;
          end
        end else begin
          bit_timer_next = bit_timer - 16'd1;
        end
      end
      urmd_pkg::PH_DATA: begin
        if (bit_timer == 16'd0) begin
          shift_byte_next = shift_byte | ({7'd0, line_level} << bit_index);
          bit_timer_next = full_reload;
          if (bit_index == urmd_pkg::LAST_BIT) begin
            phase_next = urmd_pkg::PH_STOP;
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end else begin
          bit_timer_next = bit_timer - 16'd1;
        end
      end
      urmd_pkg::PH_STOP: begin
        if (bit_timer == 16'd0) begin
          phase_next = urmd_pkg::PH_IDLE;
          if (!line_level) begin
            rec.framing_error = 1'b1;
          end else begin
            rec.byte_valid = 1'b1;
            rec.data = shift_byte;
          end
        end else begin
          bit_timer_next = bit_timer - 16'd1;
        end
      end
      default: begin
        phase_next = urmd_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

// File: design/urmd_fifo.sv
module urmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  urmd_pkg::rx_rec_t push_rec,
  input  logic              pop,
  output urmd_pkg::rx_rec_t pop_rec,
  output logic              full,
  output logic              empty
);

  urmd_pkg::rx_rec_t entries [urmd_pkg::FIFO_DEPTH];
  logic [urmd_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [urmd_pkg::FIFO_AW:0]   count;
  logic do_push, do_pop;

  assign full = (count == (urmd_pkg::FIFO_AW+1)'(urmd_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/urmd_back.sv
module urmd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              fifo_empty,
  input  urmd_pkg::rx_rec_t rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              byte_valid,
  output logic [7:0]        data_byte,
  output logic              framing_error,
  output logic              completion
);

  logic [4:0] match_position, match_position_next;
  logic       marker_found, marker_found_next;
  logic       done;

  assign pop = !fifo_empty && (!out_valid || out_ready);

  always_comb begin
    match_position_next = match_position;
    marker_found_next = marker_found;
    done = 1'b0;
    if (rec.byte_valid) begin
      if (!marker_found) begin
        if (rec.data == urmd_pkg::marker_char(match_position)) begin
          match_position_next = match_position + 5'd1;
        end else if (rec.data == urmd_pkg::marker_char(5'd0)) begin
          match_position_next = 5'd1;
        end else begin
          match_position_next = 5'd0;
        end
        if (match_position_next == urmd_pkg::MARKER_LEN) begin
          marker_found_next = 1'b1;
        end
      end else begin
        done = (rec.data == urmd_pkg::NEWLINE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= 5'd0;
      marker_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        match_position <= match_position_next;
        marker_found <= marker_found_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_valid <= rec.byte_valid;
      data_byte <= rec.data;
      framing_error <= rec.framing_error;
      completion <= done;
    end
  end

`ifndef ASSERT_OFF
  a_done_is_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && completion |-> byte_valid && (data_byte == urmd_pkg::NEWLINE))
    else $error("completion without a newline byte");
  a_valid_xor_ferr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(byte_valid && framing_error))
    else $error("byte_valid and framing_error both set");
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data_byte nonzero without a byte");
  a_found_sticks: assert property (@(posedge clk) disable iff (rst)
    marker_found |=> marker_found)
    else $error("marker_found cleared without reset");
`endif

endmodule
